// ===== hw/rtl/prt_pkg.sv =====
// Shared types and constants of the percentile rank tracker.
// Holds field widths, stream packing widths and the control state encoding.
// Depends on nothing.
package prt_pkg;

    localparam int FIELD_W    = 16;
    localparam int PAGE_W     = 10;
    localparam int CNT_W      = 17;
    localparam int RATIO_W    = 17;
    localparam int NUM_W      = CNT_W + 16;
    localparam int DIV_CNT_W  = 6;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 56;

    localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(65536);

    localparam logic FUNC_RECORD = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_LOOKUP = 8'b0000_0100,
        S_DEC    = 8'b0000_1000,
        S_INC    = 8'b0001_0000,
        S_SUM    = 8'b0010_0000,
        S_DIV    = 8'b0100_0000,
        S_RESP   = 8'b1000_0000
    } state_t;

endpackage

// ===== hw/rtl/percentile_rank_tracker.sv =====
// Percentile rank tracker: record requests pass through lookup and, as needed,
// bucket decrement and bucket increment; a rank request runs a serial bucket sum
// (one histogram read per cycle) and a 33-step restoring divider. One request
// is in work at a time; a finished result waits in the output register while
// the next request is taken.
// After reset a clearing pass over max(MAX_USERS, MAX_VALUE) addresses empties both
// memories; no request is taken until it ends.
module percentile_rank_tracker #(
    parameter int MAX_USERS = 65536,
    parameter int MAX_VALUE = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // user_id [15:0], progress [25:16], zero [31:26]
    input  logic [prt_pkg::IN_DATA_W-1:0]      s_tdata,
    // func
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // ratio [16:0], fewer_count [32:17], others_count [48:33], zero [55:49]
    output logic [prt_pkg::OUT_DATA_W-1:0]     m_tdata,
    // known
    output logic                               m_tuser
);

    localparam int UID_W = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
    localparam int VAL_W = (MAX_VALUE > 1) ? $clog2(MAX_VALUE) : 1;
    localparam int CLR_N = (MAX_USERS > MAX_VALUE) ? MAX_USERS : MAX_VALUE;
    localparam int CLR_W = $clog2(CLR_N);
    localparam int CNT_W = prt_pkg::CNT_W;
    localparam int NUM_W = prt_pkg::NUM_W;
    localparam int DCW   = prt_pkg::DIV_CNT_W;
    localparam int PAD_W = prt_pkg::OUT_DATA_W - prt_pkg::RATIO_W - 2 * prt_pkg::FIELD_W;

    // memories: user entry is {valid, value}
    logic [VAL_W:0]     user_mem [MAX_USERS];
    logic [CNT_W-1:0]   hist_mem [MAX_VALUE];

    logic               user_we;
    logic [UID_W-1:0]   user_waddr;
    logic [VAL_W:0]     user_wdata;
    logic               user_re;
    logic [UID_W-1:0]   user_raddr;
    logic [VAL_W:0]     user_rdata_reg;

    logic               hist_we;
    logic [VAL_W-1:0]   hist_waddr;
    logic [CNT_W-1:0]   hist_wdata;
    logic               hist_re;
    logic [VAL_W-1:0]   hist_raddr;
    logic [CNT_W-1:0]   hist_rdata_reg;

    // control state
    prt_pkg::state_t    state_reg, state_next;
    logic [CLR_W-1:0]   clr_idx_reg, clr_idx_next;
    logic [CNT_W-1:0]   known_users_reg, known_users_next;
    logic               pend_reg, pend_next;
    logic [VAL_W-1:0]   sum_idx_reg, sum_idx_next;
    logic [DCW-1:0]     div_cnt_reg, div_cnt_next;
    logic               m_tvalid_reg, m_tvalid_next;

    // payload
    logic               func_reg, func_next;
    logic               in_range_reg, in_range_next;
    logic [UID_W-1:0]   uid_reg, uid_next;
    logic [VAL_W-1:0]   val_reg, val_next;
    logic [VAL_W-1:0]   old_reg, old_next;
    logic [VAL_W-1:0]   mine_reg, mine_next;
    logic [CNT_W-1:0]   acc_reg, acc_next;
    logic [CNT_W-1:0]   others_reg, others_next;
    logic [CNT_W-1:0]   fewer_reg, fewer_next;
    logic [NUM_W-1:0]   num_reg, num_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic [prt_pkg::RATIO_W-1:0] quo_reg, quo_next;
    logic [prt_pkg::RATIO_W-1:0] res_ratio_reg, res_ratio_next;
    logic [prt_pkg::FIELD_W-1:0] res_fewer_reg, res_fewer_next;
    logic [prt_pkg::FIELD_W-1:0] res_others_reg, res_others_next;
    logic               res_known_reg, res_known_next;
    logic [prt_pkg::OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic               m_tuser_reg, m_tuser_next;

    logic [prt_pkg::FIELD_W-1:0] in_uid;
    logic [prt_pkg::PAGE_W-1:0]  in_page;
    logic               accept;
    logic               out_free;
    logic [CNT_W:0]     rem_sh;
    logic               div_ge;
    logic [CNT_W-1:0]   sum_total;

    assign in_uid   = s_tdata[prt_pkg::FIELD_W-1:0];
    assign in_page  = s_tdata[prt_pkg::FIELD_W +: prt_pkg::PAGE_W];
    assign s_tready = (state_reg == prt_pkg::S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // one restoring divide step
    assign rem_sh = {rem_reg, num_reg[NUM_W-1]};
    assign div_ge = rem_sh >= {1'b0, others_reg};
    assign sum_total = pend_reg ? CNT_W'(acc_reg + hist_rdata_reg) : acc_reg;

    always_ff @(posedge clk)
    begin
        if (user_we)
        begin
            user_mem[user_waddr] <= user_wdata;
        end
        if (user_re)
        begin
            user_rdata_reg <= user_mem[user_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        if (hist_re)
        begin
            hist_rdata_reg <= hist_mem[hist_raddr];
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        clr_idx_next     = clr_idx_reg;
        known_users_next = known_users_reg;
        pend_next        = pend_reg;
        sum_idx_next     = sum_idx_reg;
        div_cnt_next     = div_cnt_reg;
        m_tvalid_next    = m_tvalid_reg;
        func_next        = func_reg;
        in_range_next    = in_range_reg;
        uid_next         = uid_reg;
        val_next         = val_reg;
        old_next         = old_reg;
        mine_next        = mine_reg;
        acc_next         = acc_reg;
        others_next      = others_reg;
        fewer_next       = fewer_reg;
        num_next         = num_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        res_ratio_next   = res_ratio_reg;
        res_fewer_next   = res_fewer_reg;
        res_others_next  = res_others_reg;
        res_known_next   = res_known_reg;
        m_tdata_next     = m_tdata_reg;
        m_tuser_next     = m_tuser_reg;

        user_we    = 1'b0;
        user_waddr = uid_reg;
        user_wdata = {1'b1, val_reg};
        user_re    = 1'b0;
        user_raddr = uid_reg;
        hist_we    = 1'b0;
        hist_waddr = val_reg;
        hist_wdata = CNT_W'(hist_rdata_reg + 1'b1);
        hist_re    = 1'b0;
        hist_raddr = val_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            prt_pkg::S_CLEAR:
            begin
                user_we    = 32'(clr_idx_reg) < MAX_USERS;
                user_waddr = UID_W'(clr_idx_reg);
                user_wdata = '0;
                hist_we    = 32'(clr_idx_reg) < MAX_VALUE;
                hist_waddr = VAL_W'(clr_idx_reg);
                hist_wdata = '0;
                clr_idx_next = CLR_W'(clr_idx_reg + 1'b1);
                if (32'(clr_idx_reg) == CLR_N - 1)
                begin
                    state_next = prt_pkg::S_IDLE;
                end
            end

            prt_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    func_next     = s_tuser;
                    in_range_next = 32'(in_uid) < MAX_USERS;
                    uid_next      = UID_W'(in_uid);
                    val_next      = (32'(in_page) >= MAX_VALUE) ? VAL_W'(MAX_VALUE - 1)
                                                                : VAL_W'(in_page);
                    user_re       = 1'b1;
                    user_raddr    = UID_W'(in_uid);
                    state_next    = prt_pkg::S_LOOKUP;
                end
            end

            prt_pkg::S_LOOKUP:
            begin
                if (func_reg == prt_pkg::FUNC_RECORD)
                begin
                    if (!in_range_reg)
                    begin
                        state_next = prt_pkg::S_IDLE;
                    end
                    else if (user_rdata_reg[VAL_W])
                    begin
                        // same value: decrement and increment cancel out
                        if (user_rdata_reg[VAL_W-1:0] == val_reg)
                        begin
                            state_next = prt_pkg::S_IDLE;
                        end
                        else
                        begin
                            user_we    = 1'b1;
                            old_next   = user_rdata_reg[VAL_W-1:0];
                            hist_re    = 1'b1;
                            hist_raddr = user_rdata_reg[VAL_W-1:0];
                            state_next = prt_pkg::S_DEC;
                        end
                    end
                    else
                    begin
                        user_we          = 1'b1;
                        known_users_next = CNT_W'(known_users_reg + 1'b1);
                        hist_re          = 1'b1;
                        state_next       = prt_pkg::S_INC;
                    end
                end
                else
                begin
                    res_ratio_next  = '0;
                    res_fewer_next  = '0;
                    res_others_next = '0;
                    res_known_next  = 1'b0;
                    if (!in_range_reg || !user_rdata_reg[VAL_W])
                    begin
                        state_next = prt_pkg::S_RESP;
                    end
                    else if (known_users_reg <= CNT_W'(1))
                    begin
                        res_known_next = 1'b1;
                        res_ratio_next = prt_pkg::RATIO_ONE;
                        state_next     = prt_pkg::S_RESP;
                    end
                    else
                    begin
                        res_known_next = 1'b1;
                        mine_next      = user_rdata_reg[VAL_W-1:0];
                        others_next    = CNT_W'(known_users_reg - 1'b1);
                        sum_idx_next   = '0;
                        acc_next       = '0;
                        pend_next      = 1'b0;
                        state_next     = prt_pkg::S_SUM;
                    end
                end
            end

            prt_pkg::S_DEC:
            begin
                hist_we    = hist_rdata_reg != '0;
                hist_waddr = old_reg;
                hist_wdata = CNT_W'(hist_rdata_reg - 1'b1);
                hist_re    = 1'b1;
                state_next = prt_pkg::S_INC;
            end

            prt_pkg::S_INC:
            begin
                hist_we    = 1'b1;
                state_next = prt_pkg::S_IDLE;
            end

            prt_pkg::S_SUM:
            begin
                acc_next = sum_total;
                if (sum_idx_reg != mine_reg)
                begin
                    hist_re      = 1'b1;
                    hist_raddr   = sum_idx_reg;
                    sum_idx_next = VAL_W'(sum_idx_reg + 1'b1);
                    pend_next    = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        // clamp to the others count, then start the divide
                        fewer_next   = (acc_reg > others_reg) ? others_reg : acc_reg;
                        num_next     = {fewer_next, 16'b0};
                        rem_next     = '0;
                        quo_next     = '0;
                        div_cnt_next = DCW'(NUM_W);
                        state_next   = prt_pkg::S_DIV;
                    end
                end
            end

            prt_pkg::S_DIV:
            begin
                rem_next     = div_ge ? CNT_W'(rem_sh - {1'b0, others_reg}) : CNT_W'(rem_sh);
                quo_next     = {quo_reg[prt_pkg::RATIO_W-2:0], div_ge};
                num_next     = {num_reg[NUM_W-2:0], 1'b0};
                div_cnt_next = DCW'(div_cnt_reg - 1'b1);
                if (div_cnt_reg == DCW'(1))
                begin
                    res_ratio_next  = quo_next;
                    res_fewer_next  = fewer_reg[prt_pkg::FIELD_W-1:0];
                    res_others_next = others_reg[prt_pkg::FIELD_W-1:0];
                    state_next      = prt_pkg::S_RESP;
                end
            end

            prt_pkg::S_RESP:
            begin
                // hold until the output register frees up
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {PAD_W'(0), res_others_reg, res_fewer_reg, res_ratio_reg};
                    m_tuser_next  = res_known_reg;
                    state_next    = prt_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = prt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= prt_pkg::S_CLEAR;
            clr_idx_reg     <= '0;
            known_users_reg <= '0;
            pend_reg        <= 1'b0;
            sum_idx_reg     <= '0;
            div_cnt_reg     <= '0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_idx_reg     <= clr_idx_next;
            known_users_reg <= known_users_next;
            pend_reg        <= pend_next;
            sum_idx_reg     <= sum_idx_next;
            div_cnt_reg     <= div_cnt_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        in_range_reg   <= in_range_next;
        uid_reg        <= uid_next;
        val_reg        <= val_next;
        old_reg        <= old_next;
        mine_reg       <= mine_next;
        acc_reg        <= acc_next;
        others_reg     <= others_next;
        fewer_reg      <= fewer_next;
        num_reg        <= num_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        res_ratio_reg  <= res_ratio_next;
        res_fewer_reg  <= res_fewer_next;
        res_others_reg <= res_others_next;
        res_known_reg  <= res_known_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for percentile_rank_tracker: directed and random record and
// rank requests, with random backpressure, checked against an in-bench rank predictor.
// Depends on prt_pkg and the percentile_rank_tracker RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import prt_pkg::*;

    localparam int NUM_USERS    = 65536;
    localparam int NUM_VALUES   = 1024;
    localparam int POOL_SIZE    = 32;
    localparam int IDLE_LIMIT   = 300000;
    localparam int DRAIN_CYCLES = 1200;

    typedef struct packed {
        logic [RATIO_W-1:0] ratio;
        logic [FIELD_W-1:0] fewer;
        logic [FIELD_W-1:0] others;
        logic               known;
    } rank_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;

    // Predictor state: per-user values, histogram of values, known user count.
    bit                    user_known [NUM_USERS];
    logic [PAGE_W-1:0]     user_page  [NUM_USERS];
    int unsigned           page_bucket[NUM_VALUES];
    int unsigned           known_users;

    rank_result_t          pending_ranks[$];
    logic [FIELD_W-1:0]    user_pool[POOL_SIZE];

    int                    mismatches;
    int                    n_records;
    int                    n_queries;
    int                    n_checked;
    int                    idle_cycles;
    bit                    stall_enable;
    bit                    gap_enable;
    int                    stall_left;

    percentile_rank_tracker u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    // Mostly short pauses, now and then a long one.
    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 200);
    endfunction

    function automatic logic [PAGE_W-1:0] pick_page();
        if ($urandom_range(0, 3) == 0)
            return PAGE_W'($urandom_range(0, NUM_VALUES - 1));
        return PAGE_W'($urandom_range(0, 127));
    endfunction

    // Update the predictor for one accepted request; queue the rank a query yields.
    function automatic void apply_request(logic func, logic [FIELD_W-1:0] uid,
                                          logic [PAGE_W-1:0] page);
        rank_result_t res;
        longint       fewer;
        longint       others;
        int           b;
        if (func == FUNC_RECORD)
        begin
            if (user_known[uid])
            begin
                if (page_bucket[user_page[uid]] > 0)
                    page_bucket[user_page[uid]]--;
            end
            else
            begin
                user_known[uid] = 1'b1;
                known_users++;
            end
            user_page[uid] = page;
            page_bucket[page]++;
            n_records++;
        end
        else
        begin
            res = '0;
            if (user_known[uid])
            begin
                res.known = 1'b1;
                if (known_users <= 1)
                begin
                    res.ratio = RATIO_ONE;
                end
                else
                begin
                    fewer  = 0;
                    others = longint'(known_users) - 1;
                    for (b = 0; b < int'(user_page[uid]); b++)
                        fewer += page_bucket[b];
                    if (fewer > others)
                        fewer = others;
                    res.ratio  = RATIO_W'((fewer << 16) / others);
                    res.fewer  = FIELD_W'(fewer);
                    res.others = FIELD_W'(others);
                end
            end
            pending_ranks.insert(pending_ranks.size(), res);
            n_queries++;
        end
    endfunction

    task automatic send_request(input logic func, input logic [FIELD_W-1:0] uid,
                                input logic [PAGE_W-1:0] page);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {{(IN_DATA_W - PAGE_W - FIELD_W){1'b0}}, page, uid};
        do
            @(posedge clk);
        while (!s_tready);
        apply_request(func, uid, page);
        gap = 0;
        if (gap_enable && $urandom_range(0, 1) == 1)
            gap = pick_pause();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Output backpressure: one assignment to m_tready per edge.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            if (stall_enable && $urandom_range(0, 3) == 0)
                stall_left = pick_pause();
        end
    end

    // Compare each rank result with the oldest prediction.
    always @(posedge clk)
    begin
        rank_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_ranks.size() == 0)
            begin
                $error("unexpected rank result: tdata %h known %b", m_tdata, m_tuser);
                mismatches++;
            end
            else
            begin
                want = pending_ranks.pop_front();
                n_checked++;
                if (m_tdata[16:0] !== want.ratio)
                begin
                    $error("ratio: expected %0d, actual %0d", want.ratio, m_tdata[16:0]);
                    mismatches++;
                end
                if (m_tdata[32:17] !== want.fewer)
                begin
                    $error("fewer_count: expected %0d, actual %0d",
                           want.fewer, m_tdata[32:17]);
                    mismatches++;
                end
                if (m_tdata[48:33] !== want.others)
                begin
                    $error("others_count: expected %0d, actual %0d",
                           want.others, m_tdata[48:33]);
                    mismatches++;
                end
                if (m_tuser !== want.known)
                begin
                    $error("known: expected %0d, actual %0d", want.known, m_tuser);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: the limit covers the clearing pass after reset.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout after %0d cycles without a handshake", IDLE_LIMIT);
            $display("tb_top failed");
            $finish;
        end
    end

    task automatic test_empty_table();
        send_request(FUNC_QUERY, 16'h0000, 10'h000);
        send_request(FUNC_QUERY, 16'hFFFF, 10'h3FF);
    endtask

    task automatic test_sole_user();
        send_request(FUNC_RECORD, 16'h0000, 10'h3FF);
        send_request(FUNC_QUERY, 16'h0000, 10'h000);
        // Rewrite the same value: nothing moves.
        send_request(FUNC_RECORD, 16'h0000, 10'h3FF);
        send_request(FUNC_QUERY, 16'h0000, 10'h155);
    endtask

    task automatic test_rank_updates();
        send_request(FUNC_RECORD, 16'hFFFF, 10'h000);
        send_request(FUNC_QUERY, 16'hFFFF, 10'h000);
        send_request(FUNC_QUERY, 16'h0000, 10'h000);
        send_request(FUNC_RECORD, 16'hFFFF, 10'h3FF);
        send_request(FUNC_QUERY, 16'h0000, 10'h2AA);
        send_request(FUNC_RECORD, 16'h5A5A, 10'd512);
        send_request(FUNC_RECORD, 16'hA5A5, 10'd511);
        send_request(FUNC_QUERY, 16'h0000, 10'h000);
        send_request(FUNC_QUERY, 16'h5A5A, 10'h000);
        // Lower a value and query the users around it.
        send_request(FUNC_RECORD, 16'h0000, 10'h000);
        send_request(FUNC_QUERY, 16'hFFFF, 10'h000);
        send_request(FUNC_QUERY, 16'h0000, 10'h000);
        send_request(FUNC_QUERY, 16'h1234, 10'h3FF);
    endtask

    task automatic test_random_mix(input int count);
        int r;
        int idx;
        int i;
        for (i = 0; i < count; i++)
        begin
            r   = $urandom_range(0, 99);
            idx = $urandom_range(0, POOL_SIZE - 1);
            if (r < 45)
                send_request(FUNC_RECORD, user_pool[idx], pick_page());
            else if (r < 88)
                send_request(FUNC_QUERY, user_pool[idx],
                             PAGE_W'($urandom_range(0, NUM_VALUES - 1)));
            else if (r < 94)
                send_request(FUNC_QUERY, FIELD_W'($urandom_range(0, NUM_USERS - 1)),
                             PAGE_W'($urandom_range(0, NUM_VALUES - 1)));
            else
                send_request(FUNC_RECORD, FIELD_W'($urandom_range(0, NUM_USERS - 1)),
                             pick_page());
        end
    endtask

    initial
    begin
        int k;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = FUNC_RECORD;
        stall_enable = 1'b0;
        gap_enable   = 1'b0;
        stall_left   = 0;
        idle_cycles  = 0;
        mismatches   = 0;
        n_records    = 0;
        n_queries    = 0;
        n_checked    = 0;
        known_users  = 0;
        for (k = 0; k < NUM_VALUES; k++)
            page_bucket[k] = 0;
        user_pool[0] = 16'h0000;
        user_pool[1] = 16'hFFFF;
        for (k = 2; k < POOL_SIZE; k++)
            user_pool[k] = FIELD_W'($urandom_range(0, NUM_USERS - 1));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_sole_user();
        test_rank_updates();

        // Alternate random stretches with and without idling.
        for (k = 0; k < 8; k++)
        begin
            stall_enable = (k % 4 != 3);
            gap_enable   = (k % 4 != 3);
            test_random_mix(65);
        end
        s_tvalid <= 1'b0;

        while (pending_ranks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d record and %0d rank requests over %0d known users.",
                 n_records, n_queries, known_users);
        $display("Compared %0d rank results, %0d mismatches.", n_checked, mismatches);
        if (mismatches == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
